### rtl/core/bsks_pkg.sv
// Package for the banked sorted key search block.
// Holds table geometry, field widths, register codes and the memory request type.
// No dependencies.
package bsks_pkg;

    // Table geometry.
    localparam int PER_BANK   = 128;
    localparam int BANKS      = 8;
    localparam int TABLE_SIZE = BANKS * PER_BANK;

    // Field widths fixed by the transaction format.
    localparam int IDX_W      = 10;
    localparam int KEY_W      = 32;
    localparam int BANK_CFG_W = 4;

    // Memory address width and search bound width (the bound can equal the table size).
    localparam int ADDR_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes (word address).
    localparam logic REG_BANKS_IN_USE = 1'b0;

    // Request kinds.
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic [BANK_CFG_W-1:0] BANKS_RESET = BANK_CFG_W'(8);

    // Request to the key memory: write port and read port fields.
    typedef struct packed {
        logic                    we;
        logic [ADDR_W-1:0]       waddr;
        logic signed [KEY_W-1:0] wdata;
        logic                    re;
        logic [ADDR_W-1:0]       raddr;
    } t_mem_req;

endpackage

### rtl/core/bsks_if.sv
// Channel interfaces for the banked sorted key search block: request and response.
// Depends on bsks_pkg.
interface bsks_req_if import bsks_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [IDX_W-1:0]        entry_index;
    logic signed [KEY_W-1:0] key_value;

    modport source (output valid, req_type, entry_index, key_value, input ready);
    modport sink   (input valid, req_type, entry_index, key_value, output ready);
endinterface

interface bsks_rsp_if import bsks_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] found_index;

    modport source (output valid, found, found_index, input ready);
    modport sink   (input valid, found, found_index, output ready);
endinterface

### rtl/core/bsks_key_mem.sv
// Key table memory: one write port and one read port with a registered read.
// Depends on bsks_pkg.
module bsks_key_mem import bsks_pkg::*; (
    input  logic                    i_clk,
    input  t_mem_req                i_req,
    output logic signed [KEY_W-1:0] o_rdata
);

    logic signed [KEY_W-1:0] r_mem [TABLE_SIZE];
    logic signed [KEY_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/bsks_search_ctrl.sv
// Search sequencer: takes load and search transactions, walks the binary search
// one memory read per step and holds the result in an output register.
// Depends on bsks_pkg and bsks_if.
module bsks_search_ctrl import bsks_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    bsks_req_if.sink                i_req,
    bsks_rsp_if.source              o_rsp,
    input  logic [BANK_CFG_W-1:0]   i_banks_in_use,
    output t_mem_req                o_mem_req,
    input  logic signed [KEY_W-1:0] i_mem_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_DONE
    } t_state;

    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_lo, n_lo;
    logic [CNT_W-1:0]        r_hi, n_hi;
    logic [CNT_W-1:0]        r_mid, n_mid;
    logic signed [KEY_W-1:0] r_key, n_key;
    logic                    r_res_found, n_res_found;
    logic [IDX_W-1:0]        r_res_index, n_res_index;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_found, n_out_found;
    logic [IDX_W-1:0]        r_out_index, n_out_index;

    logic [BANK_CFG_W-1:0]   banks_sat;
    logic [CNT_W-1:0]        span;
    logic                    accept;
    logic                    key_eq;
    logic                    key_lt;
    logic [CNT_W-1:0]        step_lo;
    logic [CNT_W-1:0]        step_hi;
    logic [CNT_W-1:0]        step_mid;
    logic                    slot_free;

    // Search span: banks in use, capped at the bank count, times the bank size.
    assign banks_sat = (32'(i_banks_in_use) > BANKS) ? BANK_CFG_W'(BANKS) : i_banks_in_use;
    assign span      = CNT_W'(32'(banks_sat) * PER_BANK);

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && (r_state == ST_IDLE);
    assign slot_free   = !r_out_valid || o_rsp.ready;

    // One halving step on the key that came back from memory.
    assign key_eq   = (i_mem_rdata == r_key);
    assign key_lt   = (i_mem_rdata < r_key);
    assign step_lo  = key_lt ? (r_mid + CNT_W'(1)) : r_lo;
    assign step_hi  = key_lt ? r_hi : r_mid;
    assign step_mid = step_lo + ((step_hi - step_lo) >> 1);

    // Next-state logic and memory requests.
    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_res_found = r_res_found;
        n_res_index = r_res_index;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_index = r_out_index;

        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = ADDR_W'(i_req.entry_index);
        o_mem_req.wdata = i_req.key_value;
        o_mem_req.re    = 1'b0;
        o_mem_req.raddr = ADDR_W'(step_mid);

        // The output register drains on its own handshake.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.req_type == REQ_LOAD) begin
                        // Loads past the table end are dropped.
                        o_mem_req.we = (32'(i_req.entry_index) < TABLE_SIZE);
                    end else begin
                        n_key = i_req.key_value;
                        n_lo  = '0;
                        n_hi  = span;
                        n_mid = span >> 1;
                        if (span == '0) begin
                            n_res_found = 1'b0;
                            n_res_index = '0;
                            n_state     = ST_DONE;
                        end else begin
                            o_mem_req.re    = 1'b1;
                            o_mem_req.raddr = ADDR_W'(span >> 1);
                            n_state         = ST_CMP;
                        end
                    end
                end
            end
            ST_CMP: begin
                if (key_eq) begin
                    n_res_found = 1'b1;
                    n_res_index = IDX_W'(r_mid);
                    n_state     = ST_DONE;
                end else if (step_lo < step_hi) begin
                    n_lo         = step_lo;
                    n_hi         = step_hi;
                    n_mid        = step_mid;
                    o_mem_req.re = 1'b1;
                end else begin
                    n_res_found = 1'b0;
                    n_res_index = '0;
                    n_state     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_index = r_res_index;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_key       <= n_key;
        r_res_found <= n_res_found;
        r_res_index <= n_res_index;
        r_out_found <= n_out_found;
        r_out_index <= n_out_index;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.found_index = r_out_index;

`ifndef SYNTH
    // While comparing, the search window is never empty.
    a_window_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_lo < r_hi))
        else $error("search window empty during compare");

    // The probed entry lies inside the window.
    a_mid_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> ((r_mid >= r_lo) && (r_mid < r_hi)))
        else $error("probe index outside search window");

    // A miss always reports index zero.
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_index == '0))
        else $error("miss reported with nonzero index");

    // The table is written only when a load transaction is taken.
    a_write_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (accept && (i_req.req_type == REQ_LOAD)))
        else $error("memory write outside a load transaction");

    // A memory read is always followed by a compare cycle.
    a_read_then_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.re |=> (r_state == ST_CMP))
        else $error("memory read not followed by compare");
`endif

endmodule

### rtl/core/banked_sorted_key_search.sv
// Banked sorted key search, top level: configuration register and search core.
// A load transaction writes one key table entry. A search takes at most 11 halving
// steps for a 1024-entry span, one key memory read per step, and waits until the
// output register is free. The next transaction is taken when the previous finishes.
// Reset (synchronous, active low) clears the control state and sets banks_in_use
// to 8; the key table is undefined until loaded, with no clearing pass.
// Depends on bsks_pkg, bsks_if, bsks_key_mem and bsks_search_ctrl.
module banked_sorted_key_search import bsks_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bsks_req_if.sink              i_req,
    bsks_rsp_if.source            o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [BANK_CFG_W-1:0]   r_banks_in_use;
    logic                    cfg_write;
    logic                    reg_sel;
    t_mem_req                mem_req;
    logic signed [KEY_W-1:0] mem_rdata;

    // Register decode: banks_in_use at word 0, read back zero-extended to 32 bits.
    assign reg_sel   = (paddr[APB_ADDR_W-1:2] == REG_BANKS_IN_USE);
    assign cfg_write = psel && penable && pwrite && reg_sel;
    assign pready    = 1'b1;
    assign prdata    = reg_sel ? APB_DATA_W'(r_banks_in_use) : '0;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_banks_in_use <= BANKS_RESET;
        end else if (cfg_write) begin
            r_banks_in_use <= pwdata[BANK_CFG_W-1:0];
        end
    end

    // Search sequencer.
    bsks_search_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .o_rsp          (o_rsp),
        .i_banks_in_use (r_banks_in_use),
        .o_mem_req      (mem_req),
        .i_mem_rdata    (mem_rdata)
    );

    // Key table.
    bsks_key_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule
